/* hdl/scc_pkg.sv */
// shared types, sizes and helpers for the second-chance cache lookup
// no dependencies; imported by every module under hdl

package scc_pkg;

  // table geometry
  localparam int MAX_SLOTS = 64;
  localparam int KEY_BITS  = 64;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int NUM_W     = $clog2(MAX_SLOTS + 1);

  // port widths fixed by the interface
  localparam int KEY_IN_W  = 64;
  localparam int CFG_W     = 7;
  localparam int CNT_BITS  = 32;
  localparam int SLOT_IDX_W = 6;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(64);

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } scc_scan_st_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] victim;
  } scc_hand_st_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } scc_state_t;

  // zero acts as one, anything above the table size acts as the table size
  function automatic logic [NUM_W-1:0] clamp_entries(input logic [CFG_W-1:0] v);
    if (32'(v) > 32'(MAX_SLOTS)) begin
      return NUM_W'(MAX_SLOTS);
    end else if (v == '0) begin
      return NUM_W'(1);
    end else begin
      return NUM_W'(v);
    end
  endfunction

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    if (c == '1) begin
      return c;
    end else begin
      return c + CNT_BITS'(1);
    end
  endfunction

endpackage

/* hdl/scc_key_scan.sv */
// key store and sequential associative search, one slot compared per cycle
// depends on scc_pkg

module scc_key_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [scc_pkg::KEY_BITS-1:0]  key,
  input  logic [scc_pkg::NUM_W-1:0]     num_slots,
  input  logic [scc_pkg::MAX_SLOTS-1:0] slot_valid,
  input  logic                          wr_en,
  input  logic [scc_pkg::SLOT_W-1:0]    wr_addr,
  input  logic [scc_pkg::KEY_BITS-1:0]  wr_key,
  output scc_pkg::scc_scan_st_t         status
);
  import scc_pkg::*;

  logic [KEY_BITS-1:0] key_mem [MAX_SLOTS];

  logic                busy_r;
  logic [NUM_W-1:0]    scan_r;
  logic                rd_vld_r;
  logic [SLOT_W-1:0]   rd_idx_r;
  logic [KEY_BITS-1:0] rd_key_r;

  logic issue;
  logic match;
  logic exhaust;

  assign issue   = busy_r && (scan_r < num_slots);
  // compare the slot read last cycle, so the lowest match is found first
  assign match   = rd_vld_r && slot_valid[rd_idx_r] && (rd_key_r == key);
  assign exhaust = busy_r && !rd_vld_r && !issue;

  assign status.done = busy_r && (match || exhaust);
  assign status.hit  = match;
  assign status.idx  = rd_idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (issue) begin
      rd_key_r <= key_mem[scan_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      rd_idx_r <= '0;
    end else if (start) begin
      busy_r   <= 1'b1;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
    end else if (status.done) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else if (busy_r) begin
      rd_vld_r <= issue;
      rd_idx_r <= scan_r[SLOT_W-1:0];
      if (issue) begin
        scan_r <= scan_r + NUM_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_done_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    status.done && !start |=> !busy_r)
    else $error("scan still busy after reporting done");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    status.done && status.hit |-> (NUM_W'(status.idx) < num_slots))
    else $error("hit reported on a slot outside the active range");

  a_no_write_while_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !wr_en)
    else $error("key store written during a search");
`endif

endmodule

/* hdl/scc_clock_hand.sv */
// reference bits and clock hand; sweeps one slot per cycle, pausing for wrap steps, with a shared
// compare-and-subtract for the wrap. depends on scc_pkg

module scc_clock_hand (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [scc_pkg::NUM_W-1:0]  num_slots,
  input  logic                       set_en,
  input  logic [scc_pkg::SLOT_W-1:0] set_idx,
  output scc_pkg::scc_hand_st_t      status
);
  import scc_pkg::*;

  logic [MAX_SLOTS-1:0] ref_bits_r;
  logic [SLOT_W-1:0]    hand_r;
  logic [NUM_W-1:0]     acc_r;
  logic                 busy_r;
  logic                 wrap_r;

  logic [NUM_W-1:0] opnd;
  logic             ge_n;
  logic [NUM_W-1:0] diff;

  // one compare and subtract serves both the step and the wrap reduction
  assign opnd = wrap_r ? acc_r : (NUM_W'(hand_r) + NUM_W'(1));
  assign ge_n = opnd >= num_slots;
  assign diff = opnd - num_slots;

  assign status.done   = busy_r && !wrap_r && !ref_bits_r[hand_r];
  assign status.victim = hand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_bits_r <= '0;
      hand_r     <= '0;
      acc_r      <= '0;
      busy_r     <= 1'b0;
      wrap_r     <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      wrap_r <= 1'b0;
    end else if (set_en) begin
      ref_bits_r[set_idx] <= 1'b1;
    end else if (status.done) begin
      // hand stays on the replaced slot
      ref_bits_r[hand_r] <= 1'b1;
      busy_r             <= 1'b0;
    end else if (busy_r) begin
      if (!wrap_r) begin
        ref_bits_r[hand_r] <= 1'b0;
      end
      if (ge_n) begin
        acc_r  <= diff;
        wrap_r <= 1'b1;
      end else begin
        hand_r <= opnd[SLOT_W-1:0];
        wrap_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_victim_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    status.done && !start && !set_en |=> ref_bits_r[$past(hand_r)])
    else $error("replaced slot left without its reference bit");

  a_wrap_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_r |-> busy_r)
    else $error("wrap reduction active outside a sweep");

  a_no_set_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !set_en)
    else $error("hit marking collides with a sweep");
`endif

endmodule

/* hdl/second_chance_cache_lookup.sv */
// top level: sequencer, slot valid bits, counters and output register
// depends on scc_pkg, scc_key_scan, scc_clock_hand
//
//   channel  direction  handshake           beat payload
//   in_      input      in_valid/in_stall   lookup_key
//   out_     output     out_valid/out_stall hit, slot_index, hit_total, miss_total
//   cfg_     input      cfg_valid/cfg_ready entries_in_use
//
// a hit at slot i is found by scanning slots 0 to i: the key store gives one slot per cycle
// to a single comparator. a miss scans all n slots in use, then the hand clears each set
// reference bit it passes and takes extra wrap reduction steps before it settles on a victim.
// valid and reference bits sit in flip-flops cleared by reset; no clearing pass.
// input is stalled from acceptance until the result is in the output register;
// a waiting result does not block the next beat.

module second_chance_cache_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [scc_pkg::KEY_IN_W-1:0]   in_lookup_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit,
  output logic [scc_pkg::SLOT_IDX_W-1:0] out_slot_index,
  output logic [scc_pkg::CNT_BITS-1:0]   out_hit_total,
  output logic [scc_pkg::CNT_BITS-1:0]   out_miss_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scc_pkg::CFG_W-1:0]      cfg_entries_in_use
);
  import scc_pkg::*;

  scc_state_t state_r, state_nxt;

  logic [NUM_W-1:0]     num_slots_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [MAX_SLOTS-1:0] slot_valid_r;
  logic [CNT_BITS-1:0]  hit_cnt_r;
  logic [CNT_BITS-1:0]  miss_cnt_r;
  logic                 res_hit_r;
  logic [SLOT_W-1:0]    res_slot_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic [CNT_BITS-1:0]   out_hit_total_r;
  logic [CNT_BITS-1:0]   out_miss_total_r;

  logic in_beat;
  logic scan_start;
  logic sweep_start;
  logic set_ref;
  logic mem_wr;
  logic out_load;

  scc_scan_st_t scan_st;
  scc_hand_st_t hand_st;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_beat   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign scan_start  = in_beat;
  assign set_ref     = (state_r == ST_SEARCH) && scan_st.done && scan_st.hit;
  assign sweep_start = (state_r == ST_SEARCH) && scan_st.done && !scan_st.hit;
  assign mem_wr      = (state_r == ST_SWEEP) && hand_st.done;
  assign out_load    = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  scc_key_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (scan_start),
    .key        (in_beat ? in_lookup_key[KEY_BITS-1:0] : key_r),
    .num_slots  (num_slots_r),
    .slot_valid (slot_valid_r),
    .wr_en      (mem_wr),
    .wr_addr    (hand_st.victim),
    .wr_key     (key_r),
    .status     (scan_st)
  );

  scc_clock_hand u_hand (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (sweep_start),
    .num_slots (num_slots_r),
    .set_en    (set_ref),
    .set_idx   (scan_st.idx),
    .status    (hand_st)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (scan_st.done) state_nxt = scan_st.hit ? ST_FINISH : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (hand_st.done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_slots_r  <= clamp_entries(ENTRIES_RESET);
      slot_valid_r <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        num_slots_r <= clamp_entries(cfg_entries_in_use);
      end
      if (set_ref) begin
        hit_cnt_r <= sat_inc(hit_cnt_r);
      end
      if (sweep_start) begin
        miss_cnt_r <= sat_inc(miss_cnt_r);
      end
      if (mem_wr) begin
        slot_valid_r[hand_st.victim] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      key_r <= in_lookup_key[KEY_BITS-1:0];
    end
    if (set_ref) begin
      res_hit_r  <= 1'b1;
      res_slot_r <= scan_st.idx;
    end else if (mem_wr) begin
      res_hit_r  <= 1'b0;
      res_slot_r <= hand_st.victim;
    end
    if (out_load) begin
      out_hit_r        <= res_hit_r;
      out_slot_r       <= SLOT_IDX_W'(res_slot_r);
      out_hit_total_r  <= hit_cnt_r;
      out_miss_total_r <= miss_cnt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_slot_index = out_slot_r;
  assign out_hit_total  = out_hit_total_r;
  assign out_miss_total = out_miss_total_r;

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(scan_st.done && hand_st.done))
    else $error("search and sweep finished together");

  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result beat raised outside the finish step");

  a_hit_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> slot_valid_r[out_slot_r])
    else $error("hit reported on a slot never written");

  a_sweep_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    hand_st.done |-> (state_r == ST_SWEEP))
    else $error("hand reported a victim outside a sweep");
`endif

endmodule

/* sim/scc_checker.sv */
// lookup checker: watches the lookup, result and entries channels and checks every result beat
// keeps its own copy of the tag store, reference bits, clock hand and counters
// depends on scc_pkg for port widths

module scc_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [scc_pkg::KEY_IN_W-1:0]   in_lookup_key,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_hit,
  input  logic [scc_pkg::SLOT_IDX_W-1:0] out_slot_index,
  input  logic [scc_pkg::CNT_BITS-1:0]   out_hit_total,
  input  logic [scc_pkg::CNT_BITS-1:0]   out_miss_total,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [scc_pkg::CFG_W-1:0]      cfg_entries_in_use,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_seen,
  output int                             hits_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] slot;
    logic [CNT_BITS-1:0]   hits;
    logic [CNT_BITS-1:0]   misses;
  } lookup_result_t;

  logic [KEY_BITS-1:0] tag_store [MAX_SLOTS];
  logic                tag_valid [MAX_SLOTS];
  logic                ref_bit   [MAX_SLOTS];
  int                  hand;
  logic [CNT_BITS-1:0] hit_count;
  logic [CNT_BITS-1:0] miss_count;
  logic [CFG_W-1:0]    entries;

  lookup_result_t pending_results [$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    hits_seen    = 0;
  end

  function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // search the slots in use, then either mark the hit or run the hand to a victim
  function automatic lookup_result_t resolve_lookup(input logic [KEY_BITS-1:0] key);
    lookup_result_t r;
    int   n;
    int   s;
    logic found;
    n = (entries == 0) ? 1 : ((int'(entries) > MAX_SLOTS) ? MAX_SLOTS : int'(entries));
    found = 1'b0;
    s = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && tag_valid[i] && tag_store[i] == key) begin
        found = 1'b1;
        s = i;
      end
    end
    if (found) begin
      hit_count = count_up(hit_count);
      ref_bit[s] = 1'b1;
    end else begin
      miss_count = count_up(miss_count);
      // a hand left above a shrunk range is tested once, then wraps back in
      while (ref_bit[hand]) begin
        ref_bit[hand] = 1'b0;
        hand = (hand + 1) % n;
      end
      s = hand;
      tag_store[s] = key;
      tag_valid[s] = 1'b1;
      ref_bit[s]   = 1'b1;
    end
    r.hit    = found;
    r.slot   = SLOT_IDX_W'(s);
    r.hits   = hit_count;
    r.misses = miss_count;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        tag_store[i] = '0;
        tag_valid[i] = 1'b0;
        ref_bit[i]   = 1'b0;
      end
      hand       = 0;
      hit_count  = '0;
      miss_count = '0;
      entries    = ENTRIES_RESET;
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        entries = cfg_entries_in_use;
      end
      // result beats are checked before this edge's lookup is queued
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_hit) hits_seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with no lookup outstanding (slot %0d)", out_slot_index);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            mismatches++;
          end
          if (out_slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, out_slot_index);
            mismatches++;
          end
          if (out_hit_total !== want.hits) begin
            $error("hit_total: expected %0d, got %0d", want.hits, out_hit_total);
            mismatches++;
          end
          if (out_miss_total !== want.misses) begin
            $error("miss_total: expected %0d, got %0d", want.misses, out_miss_total);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(resolve_lookup(in_lookup_key[KEY_BITS-1:0]));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

/* sim/testbench.sv */
// top of the lookup testbench: clock, reset, stimulus phases and the verdict
// depends on scc_pkg, second_chance_cache_lookup and scc_checker

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int PHASE_ITEMS  = 192;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KEY_IN_W-1:0]   in_lookup_key = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_hit;
  logic [SLOT_IDX_W-1:0] out_slot_index;
  logic [CNT_BITS-1:0]   out_hit_total;
  logic [CNT_BITS-1:0]   out_miss_total;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_entries_in_use = ENTRIES_RESET;

  int mismatches;
  int outstanding;
  int results_seen;
  int hits_seen;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int lookups_sent = 0;
  int entries_writes = 0;

  logic [KEY_IN_W-1:0] key_pool [$];
  logic [KEY_IN_W-1:0] last_key = '0;

  second_chance_cache_lookup u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_lookup_key     (in_lookup_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_slot_index    (out_slot_index),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_entries_in_use(cfg_entries_in_use)
  );

  scc_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_lookup_key     (in_lookup_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_slot_index    (out_slot_index),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_entries_in_use(cfg_entries_in_use),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_seen      (results_seen),
    .hits_seen         (hits_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("second_chance_cache_lookup: mismatch");
      $finish;
    end
  end

  // one lookup beat, after a random idle gap; valid stays high for a following beat
  task automatic push_key(input logic [KEY_IN_W-1:0] key);
    int gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_lookup_key <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lookup_key <= key;
    do @(posedge clk); while (in_stall);
    last_key = key;
    lookups_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_entries(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_entries_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    entries_writes++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 68; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 68; end
      default: begin send_idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  // working set a little larger than the slots in use, so hits and evictions both occur
  task automatic fill_key_pool(input logic [CFG_W-1:0] v);
    int n;
    n = (v == 0) ? 1 : ((int'(v) > MAX_SLOTS) ? MAX_SLOTS : int'(v));
    key_pool.delete();
    repeat (n + n / 2 + 2) key_pool.push_back({$urandom, $urandom});
  endtask

  function automatic logic [KEY_IN_W-1:0] pick_key();
    int r;
    logic [KEY_IN_W-1:0] one_hot;
    r = $urandom_range(99);
    one_hot = KEY_IN_W'(1) << $urandom_range(KEY_IN_W - 1);
    if (r < 72) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 80) return last_key;
    if (r < 82) return '0;
    if (r < 84) return '1;
    if (r < 86) return one_hot;
    if (r < 88) return ~one_hot;
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [CFG_W-1:0] phase_entries [8];
    phase_entries = '{7'd64, 7'd1, 7'd16, 7'd3, 7'd127, 7'd33, 7'd2, 7'd0};
    phase_entries[7] = CFG_W'($urandom_range(1, 64));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys, hand above a shrunk range, clamped sizes, stale duplicates
    set_idling(0);
    push_key('0);
    push_key('1);
    push_key('0);
    push_key('1);
    push_key(64'h8000_0000_0000_0000);
    push_key(64'h0000_0000_0000_0001);
    push_key(64'h5555_5555_5555_5555);
    push_key(64'hAAAA_AAAA_AAAA_AAAA);
    push_key('0);
    write_entries(7'd2);
    push_key(64'h1234_5678_9ABC_DEF0);
    push_key(64'h0FED_CBA9_8765_4321);
    push_key('1);
    write_entries(7'd0);
    push_key(64'hDEAD_BEEF_0000_0001);
    push_key(64'hDEAD_BEEF_0000_0001);
    push_key(64'h8000_0000_0000_0000);
    // back to the full table: old copies above the small range now sit beside new ones
    write_entries(7'd127);
    push_key(64'h8000_0000_0000_0000);
    push_key(64'h5555_5555_5555_5555);
    push_key(64'hAAAA_AAAA_AAAA_AAAA);
    push_key(64'h0000_0000_0000_0001);
    write_entries(7'd65);
    push_key('0);
    push_key('1);
    push_key(64'h1234_5678_9ABC_DEF0);

    for (int p = 0; p < 8; p++) begin
      write_entries(phase_entries[p]);
      fill_key_pool(phase_entries[p]);
      set_idling(p % 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold the sender off until the block has emptied
        if (k == PHASE_ITEMS / 2) wait_drained();
        push_key(pick_key());
      end
    end

    wait_drained();
    stall_pct = 0;
    repeat (200) @(posedge clk);

    $display("lookups: %0d sent, %0d results checked (%0d hits, %0d replacements)",
             lookups_sent, results_seen, hits_seen, results_seen - hits_seen);
    $display("table sizes changed %0d times, including zero, one, the full table and above",
             entries_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("second_chance_cache_lookup: match");
    end else begin
      $display("second_chance_cache_lookup: mismatch");
    end
    $finish;
  end

endmodule
